FILE: rtl/bmmt_pkg.sv
// Shared types, constants and helper functions of the bit-wise march test sequencer.
package bmmt_pkg;

  localparam int ADDR_WIDTH = 32;
  localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = 2'd2;

  localparam logic [3:0] PASS_COUNT_RESET = 4'd3;

  // March elements
  localparam logic [2:0] EL_WRITE_ZERO = 3'd0;
  localparam logic [2:0] EL_UP_R0_W1_R1 = 3'd1;
  localparam logic [2:0] EL_UP_R1_W0   = 3'd2;
  localparam logic [2:0] EL_DN_R0_W1   = 3'd3;
  localparam logic [2:0] EL_DN_R1_W0   = 3'd4;
  localparam logic [2:0] EL_READ_ZERO  = 3'd5;

  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [7:0] MASK_LSB = 8'h01;
  localparam logic [7:0] MASK_MSB = 8'h80;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [2:0]  element;
    logic [31:0] byte_offset;
    logic [2:0]  bit_index;
    logic [1:0]  sub_step;
    logic [7:0]  held_byte;
    logic [3:0]  passes_done;
    logic        running;
    logic        fail_flag;
    logic [31:0] fail_addr;
    cmd_t        last_cmd;
    logic        finished;
  } bmmt_state_t;

  typedef struct packed {
    cmd_t        mem_cmd;
    logic [31:0] mem_address;
    logic [7:0]  write_data;
    logic [2:0]  march_element;
    logic        busy_res;
    logic        done_res;
    logic        failed;
    logic [31:0] fail_address;
  } bmmt_res_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [31:0] region_length;
    logic [3:0]  pass_count;
  } bmmt_cfg_t;

  function automatic logic is_desc(input logic [2:0] el);
    return (el == EL_DN_R0_W1) || (el == EL_DN_R1_W0);
  endfunction

  function automatic logic [7:0] bit_mask(input logic [2:0] el, input logic [2:0] bi);
    return is_desc(el) ? (MASK_MSB >> bi) : (MASK_LSB << bi);
  endfunction

  function automatic logic [31:0] cur_addr(input bmmt_cfg_t cfg, input logic [2:0] el,
                                           input logic [31:0] off);
    logic [31:0] o;
    o = is_desc(el) ? (cfg.region_length - 32'd1 - off) : off;
    return (cfg.base_address + o) & ADDR_MASK;
  endfunction

  function automatic cmd_t cur_cmd(input logic [2:0] el, input logic [1:0] sub);
    cmd_t c;
    if (el == EL_WRITE_ZERO) c = CMD_WRITE;
    else if (el == EL_READ_ZERO) c = CMD_READ;
    else c = (sub == 2'd1) ? CMD_WRITE : CMD_READ;
    return c;
  endfunction

  function automatic logic [7:0] cur_wdata(input logic [2:0] el, input logic [2:0] bi,
                                           input logic [7:0] held);
    logic [7:0] m;
    logic [7:0] d;
    m = bit_mask(el, bi);
    case (el)
      EL_UP_R0_W1_R1, EL_DN_R0_W1: d = held | m;
      EL_UP_R1_W0, EL_DN_R1_W0:    d = held & ~m;
      default:                     d = 8'h00;
    endcase
    return d;
  endfunction

  function automatic logic check_ok(input logic [2:0] el, input logic [2:0] bi,
                                    input logic [1:0] sub, input logic [7:0] rd);
    logic [7:0] m;
    logic ok;
    m = bit_mask(el, bi);
    case (el)
      EL_UP_R0_W1_R1: ok = (sub == 2'd0) ? ((rd & m) == 8'h00) : ((rd & m) != 8'h00);
      EL_UP_R1_W0, EL_DN_R1_W0: ok = (rd & m) != 8'h00;
      EL_DN_R0_W1:  ok = (rd & m) == 8'h00;
      EL_READ_ZERO: ok = rd == 8'h00;
      default:      ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/bmmt_if.sv
// Handshake channel interfaces: request input, result output, configuration writes.
interface bmmt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] read_data;
  modport source (output valid, op, read_data, input ready);
  modport sink (input valid, op, read_data, output ready);
endinterface

interface bmmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mem_cmd;
  logic [31:0] mem_address;
  logic [7:0]  write_data;
  logic [2:0]  march_element;
  logic        busy_res;
  logic        done_res;
  logic        failed;
  logic [31:0] fail_address;
  modport source (output valid, mem_cmd, mem_address, write_data, march_element,
                  busy_res, done_res, failed, fail_address, input ready);
  modport sink (input valid, mem_cmd, mem_address, write_data, march_element,
                busy_res, done_res, failed, fail_address, output ready);
endinterface

interface bmmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/bmmt_step.sv
// Next-state and result logic for one request of the march sequencer.
module bmmt_step
  import bmmt_pkg::*;
(
  input  bmmt_state_t cur,
  input  bmmt_cfg_t   cfg,
  input  logic        op,
  input  logic [7:0]  read_data,
  output bmmt_state_t nxt,
  output bmmt_res_t   res
);

  logic [31:0] off_inc;
  logic        byte_end;
  logic        elem_done;
  logic [1:0]  last_sub;
  logic [3:0]  passes_inc;

  assign off_inc    = cur.byte_offset + 32'd1;
  assign byte_end   = off_inc >= cfg.region_length;
  assign passes_inc = cur.passes_done + 4'd1;

  always_comb begin
    nxt       = cur;
    elem_done = 1'b0;
    last_sub  = (cur.element == EL_UP_R0_W1_R1) ? 2'd2 : 2'd1;
    if (op) begin
      nxt.element     = EL_WRITE_ZERO;
      nxt.byte_offset = '0;
      nxt.bit_index   = '0;
      nxt.sub_step    = '0;
      nxt.held_byte   = '0;
      nxt.passes_done = '0;
      nxt.fail_flag   = 1'b0;
      nxt.fail_addr   = '0;
      nxt.running     = cfg.region_length != 32'd0;
      nxt.finished    = cfg.region_length == 32'd0;
    end else if (cur.running) begin
      if (cur.last_cmd == CMD_READ) begin
        nxt.held_byte = read_data;
        if (!check_ok(cur.element, cur.bit_index, cur.sub_step, read_data)) begin
          nxt.fail_flag = 1'b1;
          nxt.fail_addr = cur_addr(cfg, cur.element, cur.byte_offset);
          nxt.running   = 1'b0;
          nxt.finished  = 1'b1;
        end
      end
      if (nxt.running) begin
        // walk sub-step, bit, byte
        if (cur.element == EL_WRITE_ZERO || cur.element == EL_READ_ZERO) begin
          nxt.byte_offset = off_inc;
          elem_done       = byte_end;
        end else if (cur.sub_step < last_sub) begin
          nxt.sub_step = cur.sub_step + 2'd1;
        end else begin
          nxt.sub_step = '0;
          if (cur.bit_index < LAST_BIT) begin
            nxt.bit_index = cur.bit_index + 3'd1;
          end else begin
            nxt.bit_index   = '0;
            nxt.byte_offset = off_inc;
            elem_done       = byte_end;
          end
        end
        if (elem_done) begin
          nxt.byte_offset = '0;
          nxt.bit_index   = '0;
          nxt.sub_step    = '0;
          if (cur.element < EL_READ_ZERO) begin
            nxt.element = cur.element + 3'd1;
          end else begin
            nxt.passes_done = passes_inc;
            nxt.element     = EL_WRITE_ZERO;
            if (passes_inc >= cfg.pass_count) begin
              nxt.element  = cur.element;
              nxt.running  = 1'b0;
              nxt.finished = 1'b1;
            end
          end
        end
      end
    end
    nxt.last_cmd = nxt.running ? cur_cmd(nxt.element, nxt.sub_step) : CMD_NONE;
  end

  always_comb begin
    res.mem_cmd       = nxt.last_cmd;
    res.mem_address   = (nxt.last_cmd != CMD_NONE) ?
                        cur_addr(cfg, nxt.element, nxt.byte_offset) : 32'd0;
    res.write_data    = (nxt.last_cmd == CMD_WRITE) ?
                        cur_wdata(nxt.element, nxt.bit_index, nxt.held_byte) : 8'h00;
    res.march_element = nxt.element;
    res.busy_res      = nxt.running;
    res.done_res      = nxt.finished;
    res.failed        = nxt.fail_flag;
    res.fail_address  = nxt.fail_addr;
  end

endmodule

FILE: rtl/bitwise_march_memory_test.sv
// Top level of the bit-wise march memory test sequencer.
//
// Usage:
//  - cfg_req writes base_address (index 0), region_length (1) and pass_count (2);
//    it is always ready and the new value applies from the next request on.
//  - in_req carries one request: op=1 starts a run, op=0 is a step that brings
//    the byte memory returned for the previous read command.
//  - out_res returns exactly one result per request: the next memory command
//    (none/read/write, address, write byte) plus run status and failure info.
//  - Latency: a result is valid in the cycle after its request is accepted.
//  - Throughput: one request per cycle while results are taken; the whole step (check,
//    advance, address add) sits between the state registers and the result register.
//  - in_req.ready is high whenever the result register is empty or is being
//    taken in the same cycle, so a stalled receiver holds off new requests
//    only while one finished result waits.
//  - Reset (rst_n low, synchronous) clears the run state, empties the result
//    register and restores the register defaults (pass_count 3, others 0).
//  - Steps while no run is active issue no command and show the last outcome.
module bitwise_march_memory_test
  import bmmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bmmt_cfg_if.sink    cfg_req,
  bmmt_in_if.sink     in_req,
  bmmt_out_if.source  out_res
);

  bmmt_cfg_t   cfg_r;
  bmmt_state_t state_r;
  bmmt_state_t state_nxt;
  bmmt_res_t   res_nxt;
  bmmt_res_t   out_r;
  logic        out_valid_r;
  logic        in_take;

  // configuration: always accepted
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_address  <= '0;
      cfg_r.region_length <= '0;
      cfg_r.pass_count    <= PASS_COUNT_RESET;
    end else if (cfg_req.valid) begin
      case (cfg_req.index)
        REG_BASE_ADDRESS:  cfg_r.base_address  <= cfg_req.data;
        REG_REGION_LENGTH: cfg_r.region_length <= cfg_req.data;
        REG_PASS_COUNT:    cfg_r.pass_count    <= cfg_req.data[3:0];
        default: ;
      endcase
    end
  end

  // request accepted when the result slot is free or draining
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_take      = in_req.valid && in_req.ready;

  bmmt_step u_step (
    .cur       (state_r),
    .cfg       (cfg_r),
    .op        (in_req.op),
    .read_data (in_req.read_data),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      out_r <= res_nxt;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.mem_cmd       = out_r.mem_cmd;
  assign out_res.mem_address   = out_r.mem_address;
  assign out_res.write_data    = out_r.write_data;
  assign out_res.march_element = out_r.march_element;
  assign out_res.busy_res      = out_r.busy_res;
  assign out_res.done_res      = out_r.done_res;
  assign out_res.failed        = out_r.failed;
  assign out_res.fail_address  = out_r.fail_address;

  // a run is never both active and finished
  a_run_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.running && state_r.finished))
    else $error("run active and finished together");

  // a command is only issued while a run is active
  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.mem_cmd != CMD_NONE) |-> out_r.busy_res)
    else $error("command issued outside a run");

  // a start clears pass count and failure state
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_req.op) |=> (state_r.passes_done == 4'd0 && !state_r.fail_flag
                                && state_r.element == EL_WRITE_ZERO))
    else $error("start did not clear run state");

  // element index stays within the march
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.element <= EL_READ_ZERO)
    else $error("march element out of range");

  // a failure always ends the run
  a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.fail_flag |-> (state_r.finished && !state_r.running))
    else $error("failure without finished run");

endmodule

FILE: dv/tb.sv
// Testbench of the bit-wise march memory test sequencer: predictor, scoreboard and stimulus.
module tb;
  import bmmt_pkg::*;

  // Keeps its own copy of the registers and of the sequencer state. Each accepted
  // request produces exactly one expected result, which waits in a queue until the
  // block returns the matching result.
  class march_scoreboard;
    logic [31:0] base;
    logic [31:0] length;
    logic [3:0]  pass_target;
    logic [2:0]  elem;
    logic [31:0] offset;
    logic [2:0]  bit_pos;
    logic [1:0]  sub;
    logic [7:0]  held;
    logic [3:0]  passes;
    logic        active;
    logic        fail_seen;
    logic [31:0] fail_at;
    cmd_t        last_cmd;
    logic        finished;
    bmmt_res_t   awaited[$];
    bmmt_res_t   last_issue;
    int          errors;

    function void clear();
      base = '0;
      length = '0;
      pass_target = PASS_COUNT_RESET;
      start_element(EL_WRITE_ZERO);
      held = '0;
      passes = '0;
      active = 1'b0;
      fail_seen = 1'b0;
      fail_at = '0;
      last_cmd = CMD_NONE;
      finished = 1'b0;
      last_issue = '0;
      awaited.delete();
      errors = 0;
    endfunction

    function void apply_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_BASE_ADDRESS:  base = value;
        REG_REGION_LENGTH: length = value;
        REG_PASS_COUNT:    pass_target = value[3:0];
        default: ;
      endcase
    endfunction

    function logic going_down();
      return (elem == EL_DN_R0_W1) || (elem == EL_DN_R1_W0);
    endfunction

    function logic [7:0] bit_select();
      return going_down() ? (MASK_MSB >> bit_pos) : (MASK_LSB << bit_pos);
    endfunction

    // descending elements walk the region from its top byte
    function logic [31:0] target_address();
      logic [31:0] rel;
      rel = going_down() ? (length - 32'd1 - offset) : offset;
      return (base + rel) & ADDR_MASK;
    endfunction

    function cmd_t command_due();
      cmd_t c;
      if (elem == EL_WRITE_ZERO) c = CMD_WRITE;
      else if (elem == EL_READ_ZERO) c = CMD_READ;
      else c = (sub == 2'd1) ? CMD_WRITE : CMD_READ;
      return c;
    endfunction

    function logic [7:0] byte_to_write();
      logic [7:0] d;
      case (elem)
        EL_UP_R0_W1_R1, EL_DN_R0_W1: d = held | bit_select();
        EL_UP_R1_W0, EL_DN_R1_W0:    d = held & ~bit_select();
        default:                     d = 8'h00;
      endcase
      return d;
    endfunction

    function logic read_matches(logic [7:0] rd);
      logic [7:0] hit;
      logic ok;
      hit = rd & bit_select();
      case (elem)
        EL_UP_R0_W1_R1: ok = (sub == 2'd0) ? (hit == 8'h00) : (hit != 8'h00);
        EL_UP_R1_W0, EL_DN_R1_W0: ok = hit != 8'h00;
        EL_DN_R0_W1:  ok = hit == 8'h00;
        EL_READ_ZERO: ok = rd == 8'h00;
        default:      ok = 1'b1;
      endcase
      return ok;
    endfunction

    function void start_element(logic [2:0] e);
      elem = e;
      offset = '0;
      bit_pos = '0;
      sub = '0;
    endfunction

    function void advance_march();
      logic done;
      done = 1'b0;
      if (elem == EL_WRITE_ZERO || elem == EL_READ_ZERO) begin
        offset = offset + 32'd1;
        done = offset >= length;
      end else if (sub < ((elem == EL_UP_R0_W1_R1) ? 2'd2 : 2'd1)) begin
        sub = sub + 2'd1;
      end else begin
        sub = '0;
        if (bit_pos != LAST_BIT) begin
          bit_pos = bit_pos + 3'd1;
        end else begin
          bit_pos = '0;
          offset = offset + 32'd1;
          done = offset >= length;
        end
      end
      if (!done) return;
      if (elem != EL_READ_ZERO) begin
        start_element(elem + 3'd1);
        return;
      end
      passes = passes + 4'd1;
      if (passes >= pass_target) begin
        active = 1'b0;
        finished = 1'b1;
      end else begin
        start_element(EL_WRITE_ZERO);
      end
    endfunction

    function void note_request(logic op, logic [7:0] rd);
      bmmt_res_t r;
      if (op) begin
        start_element(EL_WRITE_ZERO);
        held = '0;
        passes = '0;
        fail_seen = 1'b0;
        fail_at = '0;
        active = length != 32'd0;
        finished = length == 32'd0;
      end else if (active) begin
        // read data only counts when the last command was a read
        if (last_cmd == CMD_READ) begin
          held = rd;
          if (!read_matches(rd)) begin
            fail_seen = 1'b1;
            fail_at = target_address();
            active = 1'b0;
            finished = 1'b1;
          end
        end
        if (active) advance_march();
      end
      last_cmd = active ? command_due() : CMD_NONE;
      r.mem_cmd = last_cmd;
      r.mem_address = (last_cmd != CMD_NONE) ? target_address() : '0;
      r.write_data = (last_cmd == CMD_WRITE) ? byte_to_write() : '0;
      r.march_element = elem;
      r.busy_res = active;
      r.done_res = finished;
      r.failed = fail_seen;
      r.fail_address = fail_at;
      awaited.push_back(r);
      last_issue = r;
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("[%0t] %s mismatch: expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(bmmt_res_t got);
      bmmt_res_t want;
      if (awaited.size() == 0) begin
        $display("[%0t] unexpected result: cmd %0h addr %0h", $time, got.mem_cmd,
                 got.mem_address);
        errors++;
        return;
      end
      want = awaited.pop_front();
      field_check("mem_cmd", 32'(want.mem_cmd), 32'(got.mem_cmd));
      field_check("mem_address", want.mem_address, got.mem_address);
      field_check("write_data", 32'(want.write_data), 32'(got.write_data));
      field_check("march_element", 32'(want.march_element), 32'(got.march_element));
      field_check("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      field_check("done_res", 32'(want.done_res), 32'(got.done_res));
      field_check("failed", 32'(want.failed), 32'(got.failed));
      field_check("fail_address", want.fail_address, got.fail_address);
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        $display("[%0t] %0d results never arrived", $time, awaited.size());
        errors += awaited.size();
      end
    endfunction
  endclass

  localparam int ITEM_TARGET = 1750;

  logic clk = 1'b0;
  logic rst_n;

  bmmt_in_if  in_ch ();
  bmmt_out_if out_ch ();
  bmmt_cfg_if cfg_ch ();

  bitwise_march_memory_test DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_req (cfg_ch),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  march_scoreboard march_sb = new();

  // Memory the sequencer is testing: writes land here as they are issued, and
  // reads are answered from it so that clean runs get through every element.
  logic [7:0] mem_image [bit [31:0]];

  int sent_items = 0;
  bit no_gaps = 1'b0;   // set for whole phases to get stretches without idling

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(24, 4);
  endfunction

  // Correct byte for the command just issued; anything after a write or no
  // command is ignored by the block, so random noise goes there.
  function automatic logic [7:0] march_reply();
    bmmt_res_t cmd;
    cmd = march_sb.last_issue;
    if (cmd.mem_cmd == CMD_READ && mem_image.exists(cmd.mem_address))
      return mem_image[cmd.mem_address];
    return 8'($urandom);
  endfunction

  // valid stays high across back-to-back requests; it is only lowered for a gap
  task automatic send_request(input logic op, input logic [7:0] rd);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.read_data <= rd;
    do @(posedge clk); while (!in_ch.ready);
    march_sb.note_request(op, rd);
    if (march_sb.last_issue.mem_cmd == CMD_WRITE)
      mem_image[march_sb.last_issue.mem_address] = march_sb.last_issue.write_data;
    sent_items++;
  endtask

  // Wait until every request has its result, plus a margin after the last one.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (march_sb.awaited.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    march_sb.apply_register(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] len,
                           input logic [31:0] passes);
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_REGION_LENGTH, len);
    write_register(REG_PASS_COUNT, passes);
  endtask

  // One run: a start request, then steps answered from the memory image. A bad
  // byte, a fresh start part way or a register rewrite can be dropped in.
  task automatic run_march(input int cap, input int abort_at, input int fault_at,
                           input int retune_at);
    logic [7:0] rd;
    bit faulted;
    faulted = 1'b0;
    send_request(1'b1, 8'($urandom));
    for (int n = 1; n <= cap && march_sb.active && sent_items < ITEM_TARGET; n++) begin
      rd = march_reply();
      if (fault_at != 0 && n >= fault_at && !faulted &&
          march_sb.last_issue.mem_cmd == CMD_READ) begin
        rd ^= 8'($urandom_range(255, 1));
        faulted = 1'b1;
      end
      if (n == retune_at) begin
        // registers rewritten mid-run take effect on the next step
        settle();
        if ($urandom_range(1))
          write_register(REG_BASE_ADDRESS, $urandom);
        else
          write_register(REG_REGION_LENGTH, $urandom_range(3));
      end
      send_request((n == abort_at) ? 1'b1 : 1'b0, rd);
    end
  endtask

  // Result side: check whatever is taken, then pick ready for the next cycle.
  initial begin
    int stall;
    bmmt_res_t got;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.mem_cmd = cmd_t'(out_ch.mem_cmd);
        got.mem_address = out_ch.mem_address;
        got.write_data = out_ch.write_data;
        got.march_element = out_ch.march_element;
        got.busy_res = out_ch.busy_res;
        got.done_res = out_ch.done_res;
        got.failed = out_ch.failed;
        got.fail_address = out_ch.fail_address;
        march_sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    int sel;
    int len_sel;
    logic [31:0] base;
    logic [31:0] len;
    logic [31:0] passes;
    int cap;
    int span;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= 1'b0;
    in_ch.read_data <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_BASE_ADDRESS;
    cfg_ch.data <= 32'h0;
    march_sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: empty region, three passes.
    send_request(1'b0, 8'hFF);    // step with no run since reset
    send_request(1'b1, 8'h00);    // empty region passes at once
    send_request(1'b0, 8'hA5);    // step while idle keeps the outcome
    settle();

    // Region straddling the top of the address space; pass count written as
    // 0x10 so only zero lands in the 4-bit register, which still means one pass.
    configure(32'hFFFF_FFFF, 32'd2, 32'h0000_0010);
    send_request(1'b1, 8'h00);
    send_request(1'b0, 8'hFF);    // read data after a write is ignored
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'h00);    // bit 0 reads as 0
    send_request(1'b0, 8'h5A);
    send_request(1'b1, 8'h00);    // start while running abandons the run
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hFE);
    send_request(1'b0, 8'h00);    // bit 0 should now be 1: first failure
    send_request(1'b0, 8'h3C);
    settle();

    // Largest region and pass count; left running, the next start abandons it.
    configure(32'h0000_0000, 32'hFFFF_FFFF, 32'd15);
    send_request(1'b1, 8'h00);
    repeat (3) send_request(1'b0, 8'($urandom));

    // Random runs: mostly clean marches over tiny regions, some with a bad byte,
    // a restart or a register rewrite part way, a few over huge regions.
    while (sent_items < ITEM_TARGET) begin
      settle();
      no_gaps = $urandom_range(3) == 0;
      sel = $urandom_range(99);
      if (sel < 10) base = 32'hFFFF_FFFF - $urandom_range(2);
      else if (sel < 20) base = 32'h0;
      else base = $urandom;
      len_sel = $urandom_range(99);
      if (len_sel < 4) len = 32'd0;
      else if (len_sel < 8) len = $urandom | 32'h8000_0000;
      else if (len_sel < 55) len = 32'd1;
      else if (len_sel < 85) len = 32'd2;
      else len = 32'd3;
      sel = $urandom_range(99);
      if (sel < 15) passes = 32'd0;
      else if (sel < 55) passes = 32'd1;
      else if (sel < 80) passes = 32'd2;
      else if (sel < 95) passes = 32'd3;
      else passes = 32'd15;
      cap = 100000;
      if (len_sel >= 4 && len_sel < 8) cap = $urandom_range(60, 20);
      if (passes == 32'd15) begin
        len = 32'd1;
        cap = $urandom_range(400, 150);
      end
      span = 74 * ((len > 32'd3) ? 1 : int'(len) + 1);
      configure(base, len, passes | (32'($urandom_range(1)) << 8));
      run_march(cap,
                ($urandom_range(4) == 0) ? $urandom_range(span, 1) : 0,
                ($urandom_range(9) < 3) ? $urandom_range(span * 2, 1) : 0,
                ($urandom_range(11) == 0) ? $urandom_range(span, 1) : 0);
      repeat ($urandom_range(2)) send_request(1'b0, 8'($urandom));
    end

    in_ch.valid <= 1'b0;
    for (int k = 0; k < 5000 && march_sb.awaited.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    march_sb.close_out();
    if (march_sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
